### sv/rbd_pkg.sv
package rbd_pkg;

    // Store geometry.
    localparam int DEPTH   = 128;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;

    // Field widths of the request and result words.
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_WRITE,
        MEM_READ
    } mem_op_t;

    // Request word.
    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [DATA_W-1:0]  push_value;
    } rbd_req_t;

    // Result word.
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [DATA_W-1:0]  popped_value;
    } rbd_rsp_t;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        mem_op_t                   op;
        logic [IDX_W-1:0]          addr;
        logic [DATA_W-1:0]         data;
        status_t                   status;
        logic [COUNT_W-1:0]        count;
    } rbd_cmd_t;

    // Circular index step forward.
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    // Circular index step backward.
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == '0) begin
            r = IDX_W'(DEPTH - 1);
        end else begin
            r = i - 1'b1;
        end
        return r;
    endfunction

endpackage

### sv/rbd_front.sv
module rbd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_ready,
    input  rbd_pkg::rbd_req_t in_req,
    output logic              cmd_valid,
    output rbd_pkg::rbd_cmd_t cmd
);

    logic [rbd_pkg::IDX_W-1:0] head_reg, head_next;
    logic [rbd_pkg::IDX_W-1:0] tail_reg, tail_next;
    logic [rbd_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      is_full;
    logic                      is_empty;
    logic                      accept;

    assign accept    = in_valid && in_ready;
    assign cmd_valid = in_valid;
    assign is_full   = (count_reg == rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
    assign is_empty  = (count_reg == '0);

    // Classify the request against the current indexes and count, and work out
    // the store access and the state after it.
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        cmd.op     = rbd_pkg::MEM_NONE;
        cmd.addr   = head_reg;
        cmd.data   = in_req.push_value;
        cmd.status = rbd_pkg::STATUS_DONE;
        unique case (rbd_pkg::req_type_t'(in_req.req_type))
            rbd_pkg::REQ_PUSH_FRONT: begin
                if (is_full) begin
                    cmd.status = rbd_pkg::STATUS_FULL;
                end else begin
                    cmd.op     = rbd_pkg::MEM_WRITE;
                    count_next = count_reg + 1'b1;
                    if (is_empty) begin
                        // The first entry goes in at the head; the tail follows it.
                        cmd.addr  = head_reg;
                        tail_next = rbd_pkg::idx_inc(head_reg);
                    end else begin
                        head_next = rbd_pkg::idx_dec(head_reg);
                        cmd.addr  = head_next;
                    end
                end
            end
            rbd_pkg::REQ_PUSH_BACK: begin
                if (is_full) begin
                    cmd.status = rbd_pkg::STATUS_FULL;
                end else begin
                    cmd.op     = rbd_pkg::MEM_WRITE;
                    cmd.addr   = tail_reg;
                    tail_next  = rbd_pkg::idx_inc(tail_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            rbd_pkg::REQ_POP_FRONT: begin
                if (is_empty) begin
                    cmd.status = rbd_pkg::STATUS_EMPTY;
                end else begin
                    cmd.op     = rbd_pkg::MEM_READ;
                    cmd.addr   = head_reg;
                    head_next  = rbd_pkg::idx_inc(head_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            rbd_pkg::REQ_POP_BACK: begin
                if (is_empty) begin
                    cmd.status = rbd_pkg::STATUS_EMPTY;
                end else begin
                    cmd.op     = rbd_pkg::MEM_READ;
                    tail_next  = rbd_pkg::idx_dec(tail_reg);
                    cmd.addr   = tail_next;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                cmd.op = rbd_pkg::MEM_NONE;
            end
        endcase
        cmd.count = rbd_pkg::COUNT_W'(count_next);
    end

    // Index and count registers advance only on an accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (accept) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

### sv/rbd_queue.sv
module rbd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  rbd_pkg::rbd_cmd_t wr_cmd,
    output logic              rd_valid,
    input  logic              rd_ready,
    output rbd_pkg::rbd_cmd_t rd_cmd
);

    rbd_pkg::rbd_cmd_t          slots [rbd_pkg::QUEUE_DEPTH];
    logic [rbd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rbd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rbd_pkg::QCNT_W-1:0] fill_reg, fill_next;
    logic                       push;
    logic                       pop;

    assign wr_ready = (fill_reg != rbd_pkg::QCNT_W'(rbd_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = slots[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            if (wr_ptr_reg == rbd_pkg::QPTR_W'(rbd_pkg::QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop) begin
            if (rd_ptr_reg == rbd_pkg::QPTR_W'(rbd_pkg::QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Command slots hold payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

### sv/rbd_back.sv
module rbd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rbd_pkg::rbd_cmd_t cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output rbd_pkg::rbd_rsp_t out_rsp
);

    logic [rbd_pkg::DATA_W-1:0]   entry_mem [rbd_pkg::DEPTH];
    logic [rbd_pkg::DATA_W-1:0]   rdata_reg;

    // Access stage: the command whose store access has been made.
    logic                         a_valid_reg, a_valid_next;
    rbd_pkg::status_t             a_status_reg;
    logic [rbd_pkg::COUNT_W-1:0]  a_count_reg;
    logic                         a_is_read_reg;

    // Output stage.
    logic                         b_valid_reg, b_valid_next;
    rbd_pkg::rbd_rsp_t            b_rsp_reg;

    logic                         b_free;
    logic                         a_adv;
    logic                         a_free;
    logic                         issue;

    assign b_free    = !b_valid_reg || out_ready;
    assign a_adv     = a_valid_reg && b_free;
    assign a_free    = !a_valid_reg || b_free;
    assign cmd_ready = a_free;
    assign issue     = cmd_valid && a_free;
    assign out_valid = b_valid_reg;
    assign out_rsp   = b_rsp_reg;

    // Stage occupancy.
    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (issue) begin
            a_valid_next = 1'b1;
        end else if (a_adv) begin
            a_valid_next = 1'b0;
        end
        if (a_adv) begin
            b_valid_next = 1'b1;
        end else if (out_ready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Entry store: one access per issued command, read data registered.
    always_ff @(posedge aclk) begin
        if (issue && (cmd.op == rbd_pkg::MEM_WRITE)) begin
            entry_mem[cmd.addr] <= cmd.data;
        end
        if (issue && (cmd.op == rbd_pkg::MEM_READ)) begin
            rdata_reg <= entry_mem[cmd.addr];
        end
    end

    // Access stage payload.
    always_ff @(posedge aclk) begin
        if (issue) begin
            a_status_reg  <= cmd.status;
            a_count_reg   <= cmd.count;
            a_is_read_reg <= (cmd.op == rbd_pkg::MEM_READ);
        end
    end

    // Output register; a refused pop or any push returns zero as the value.
    always_ff @(posedge aclk) begin
        if (a_adv) begin
            b_rsp_reg.status       <= a_status_reg;
            b_rsp_reg.entry_count  <= a_count_reg;
            b_rsp_reg.popped_value <= a_is_read_reg ? rdata_reg : '0;
        end
    end

endmodule

### sv/ring_buffer_deque_top.sv
// Double-ended queue of rbd_pkg::DEPTH signed 32-bit entries in a circular
// store. Each request word pushes at the front or back or pops from the front
// or back, and returns exactly one result word with the status, the entry count
// after the request and, for a successful pop, the removed value. The front part
// keeps the head, tail and count and classifies each word as it is accepted, so
// one request per cycle is accepted while the command queue has room; the back
// part makes one store access per cycle while its results are taken, which sets
// the sustained rate at one word per cycle. A result passes through the command queue,
// the access stage and the output register before it is offered. The store needs no
// clearing after reset, and a pop only reads entries that an earlier push wrote.
module ring_buffer_deque_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rbd_pkg::rbd_req_t s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output rbd_pkg::rbd_rsp_t m_rsp
);

    logic              front_valid;
    rbd_pkg::rbd_cmd_t front_cmd;
    logic              q_valid;
    logic              q_ready;
    rbd_pkg::rbd_cmd_t q_cmd;

    // Front part: request classification and index state.
    rbd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (s_req),
        .cmd_valid (front_valid),
        .cmd       (front_cmd)
    );

    // Command queue decouples acceptance from the store access.
    rbd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (s_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    // Back part: store access and result word.
    rbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rsp   (m_rsp)
    );

endmodule
